@@ rtl/bole_pkg.sv @@
// Shared types and constants for the bounded ordered list engine.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bole_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int HANDLE_BITS_DEF = 32;

    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_GET    = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic rem;
    } bole_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/bole_cell.sv @@
// One storage cell of the list chain: holds one entry and moves it to or from its neighbors.
// Depends on bole_pkg for the shift command type.
`timescale 1ns / 1ps
`default_nettype none

module bole_cell
    import bole_pkg::*;
#(
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    parameter int PW          = POS_W,
    parameter int INDEX       = 0
)
(
    input  wire logic                   clk,
    input  wire bole_ctrl_t             ctrl,
    input  wire logic [PW-1:0]          pos,
    input  wire logic [PW-1:0]          cnt,
    input  wire logic [HANDLE_BITS-1:0] handle,
    input  wire logic [HANDLE_BITS-1:0] lower,
    input  wire logic [HANDLE_BITS-1:0] upper,
    output      logic [HANDLE_BITS-1:0] entry,
    output      logic [HANDLE_BITS-1:0] sel_data,
    output      logic                   hit
);

    localparam logic [PW-1:0] IDX    = PW'(INDEX);
    localparam logic [PW-1:0] IDX_P1 = PW'(INDEX + 1);

    logic [HANDLE_BITS-1:0] entry_reg;
    logic [HANDLE_BITS-1:0] entry_next;
    logic                   load;

    always_comb
    begin
        entry_next = entry_reg;
        load       = 1'b0;
        if (ctrl.ins)
        begin
            if (IDX == pos)
            begin
                entry_next = handle;
                load       = 1'b1;
            end
            else if ((IDX > pos) && (IDX <= cnt))
            begin
                entry_next = lower;
                load       = 1'b1;
            end
        end
        else if (ctrl.rem)
        begin
            if ((IDX >= pos) && (IDX_P1 < cnt))
            begin
                entry_next = upper;
                load       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry    = entry_reg;
    assign sel_data = (IDX == pos) ? entry_reg : '0;
    assign hit      = (IDX < cnt) && (entry_reg == handle);

endmodule

`default_nettype wire

@@ rtl/bounded_ordered_list_engine.sv @@
// Bounded ordered list engine: a chain of storage cells plus request decode and result register.
// Depends on bole_pkg and bole_cell.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one request: operation, position and
//   item_value. The output channel (out_valid/out_ready) returns one result per request:
//   success, read_value, found, length and is_empty.
//   Every cell of the chain decides in the same cycle whether to keep its entry, take its
//   lower or upper neighbor, or load the new handle, so insert and remove shift the whole
//   list at once; search compares all cells in parallel and get selects one cell.
//   The result is registered: out_valid rises in the cycle after the input transfer. Throughput is one request
//   per cycle, limited only by the single result register: a new request is taken in the
//   same cycle the pending result is transferred out.
//   While the receiver stalls, the result holds and in_ready stays low once the result
//   register is full.
//   Reset empties the list (length zero) and clears out_valid; list contents need no
//   clearing because only positions below the length are ever read.
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_list_engine
    import bole_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [OP_W-1:0]   operation,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [DATA_W-1:0] item_value,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      logic              success,
    output      logic [DATA_W-1:0] read_value,
    output      logic              found,
    output      logic [LEN_W-1:0]  length,
    output      logic              is_empty
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int WW = (HANDLE_BITS > DATA_W) ? HANDLE_BITS : DATA_W;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   out_valid_reg;
    logic                   success_reg;
    logic [DATA_W-1:0]      read_value_reg;
    logic                   found_reg;
    logic [LEN_W-1:0]       length_reg;
    logic                   is_empty_reg;

    logic                   accept;
    logic [PW-1:0]          pos_ext;
    logic [PW-1:0]          cnt_ext;
    logic [PW-1:0]          ins_pos;
    logic [WW-1:0]          item_wide;
    logic [HANDLE_BITS-1:0] handle;
    logic                   ins_ok;
    logic                   rem_ok;
    logic                   get_ok;
    logic                   is_search;
    bole_ctrl_t             ctrl;
    logic [PW-1:0]          cell_pos;

    logic [HANDLE_BITS-1:0] ent      [CAPACITY];
    logic [HANDLE_BITS-1:0] sel_data [CAPACITY];
    logic [CAPACITY-1:0]    hits;
    logic [HANDLE_BITS-1:0] get_data;
    logic [WW-1:0]          get_wide;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;

    assign pos_ext   = PW'(position);
    assign cnt_ext   = PW'(count_reg);
    assign item_wide = WW'(item_value);
    assign handle    = item_wide[HANDLE_BITS-1:0];

    always_comb
    begin
        ins_ok    = 1'b0;
        rem_ok    = 1'b0;
        get_ok    = 1'b0;
        is_search = 1'b0;
        ins_pos   = pos_ext;
        case (operation)
            OP_APPEND:
            begin
                ins_ok  = (cnt_ext < CAP_P);
                ins_pos = cnt_ext;
            end
            OP_INSERT: ins_ok    = (pos_ext <= cnt_ext) && (cnt_ext < CAP_P);
            OP_REMOVE: rem_ok    = (pos_ext < cnt_ext);
            OP_GET:    get_ok    = (pos_ext < cnt_ext);
            OP_SEARCH: is_search = 1'b1;
            default:   ins_ok    = 1'b0;
        endcase
    end

    assign ctrl.ins = accept && ins_ok;
    assign ctrl.rem = accept && rem_ok;
    assign cell_pos = ins_pos;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [HANDLE_BITS-1:0] lower_d;
            logic [HANDLE_BITS-1:0] upper_d;
            if (g == 0)
            begin : g_first
                assign lower_d = '0;
            end
            else
            begin : g_mid_lo
                assign lower_d = ent[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign upper_d = '0;
            end
            else
            begin : g_mid_hi
                assign upper_d = ent[g+1];
            end

            bole_cell #(
                .HANDLE_BITS (HANDLE_BITS),
                .PW          (PW),
                .INDEX       (g)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .pos      (cell_pos),
                .cnt      (cnt_ext),
                .handle   (handle),
                .lower    (lower_d),
                .upper    (upper_d),
                .entry    (ent[g]),
                .sel_data (sel_data[g]),
                .hit      (hits[g])
            );
        end
    endgenerate

    // Only the cell whose index matches the position drives nonzero data.
    always_comb
    begin
        get_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            get_data = get_data | sel_data[i];
        end
    end

    assign get_wide = WW'(get_data);

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rem_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            success_reg    <= ins_ok || rem_ok || get_ok || is_search;
            read_value_reg <= get_ok ? get_wide[DATA_W-1:0] : '0;
            found_reg      <= is_search && (|hits);
            length_reg     <= LEN_W'(count_next);
            is_empty_reg   <= (count_next == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign success    = success_reg;
    assign read_value = read_value_reg;
    assign found      = found_reg;
    assign length     = length_reg;
    assign is_empty   = is_empty_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_bounded_ordered_list_engine.sv @@
// Self-checking testbench for the bounded ordered list engine: random and directed list
// operations, a queue-based list predictor and a result checker on the output channel.
// Depends on bole_pkg and the bounded_ordered_list_engine RTL.
`timescale 1ns / 1ps

module tb_bounded_ordered_list_engine;
    import bole_pkg::*;

    localparam int CLK_HALF_NS = 6;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_LIMIT = 2000;
    localparam int PRINT_LIMIT = 100;
    localparam int HOLD_CYCLES = 60;

    // Codes outside the defined operation set; the block must reject them.
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic [DATA_W-1:0] HANDLE_MASK = DATA_W'((65'd1 << HANDLE_BITS_DEF) - 65'd1);
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    typedef struct packed {
        logic              success;
        logic [DATA_W-1:0] read_value;
        logic              found;
        logic [LEN_W-1:0]  length;
        logic              is_empty;
    } list_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] item_value;
    logic              out_valid;
    logic              out_ready;
    logic              success;
    logic [DATA_W-1:0] read_value;
    logic              found;
    logic [LEN_W-1:0]  length;
    logic              is_empty;

    logic [DATA_W-1:0] list_shadow[$];
    list_result_t      expected_results[$];
    int                mismatch_count = 0;
    int                result_index = 0;
    bit                steady = 1'b0;
    bit                growing = 1'b1;
    int                long_hold_cycles = 0;

    bounded_ordered_list_engine #(
        .CAPACITY(CAPACITY_DEF),
        .HANDLE_BITS(HANDLE_BITS_DEF)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .position(position),
        .item_value(item_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .success(success),
        .read_value(read_value),
        .found(found),
        .length(length),
        .is_empty(is_empty)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: result %0d mismatch: %s", $realtime, result_index, msg);
    endtask

    // Updates the list shadow and returns the result the block must produce.
    function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [DATA_W-1:0] val);
        list_result_t res;
        logic [DATA_W-1:0] handle;
        int p;
        handle = val & HANDLE_MASK;
        p = int'(pos);
        res = '0;
        case (op)
            OP_APPEND:
                if (list_shadow.size() < CAPACITY_DEF)
                begin
                    list_shadow.push_back(handle);
                    res.success = 1'b1;
                end
            OP_INSERT:
                if (p <= list_shadow.size() && list_shadow.size() < CAPACITY_DEF)
                begin
                    list_shadow.insert(p, handle);
                    res.success = 1'b1;
                end
            OP_REMOVE:
                if (p < list_shadow.size())
                begin
                    list_shadow.delete(p);
                    res.success = 1'b1;
                end
            OP_GET:
                if (p < list_shadow.size())
                begin
                    res.read_value = list_shadow[p];
                    res.success = 1'b1;
                end
            OP_SEARCH:
            begin
                res.success = 1'b1;
                foreach (list_shadow[i])
                    if (list_shadow[i] == handle)
                        res.found = 1'b1;
            end
            default:
                ;
        endcase
        res.length = LEN_W'(list_shadow.size());
        res.is_empty = (list_shadow.size() == 0);
        return res;
    endfunction

    // Mostly back-to-back, sometimes a short gap, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // Largely valid positions up to top, the rest out of range, a few far beyond capacity.
    function automatic logic [POS_W-1:0] pick_position(input int top);
        int r;
        r = $urandom_range(0, 99);
        if (top >= 0 && r < 85)
            return POS_W'($urandom_range(0, top));
        if (r < 97)
            return POS_W'($urandom_range(top + 1, CAPACITY_DEF));
        return POS_W'($urandom_range(CAPACITY_DEF + 1, 127));
    endfunction

    // Handles from a small pool repeat often so that searches hit and duplicates appear.
    function automatic logic [DATA_W-1:0] pick_handle(input int from_list_pct);
        int r;
        int idx;
        r = $urandom_range(0, 99);
        if (r < from_list_pct && list_shadow.size() != 0)
            return list_shadow[$urandom_range(0, list_shadow.size() - 1)];
        if (r < 60)
        begin
            idx = $urandom_range(0, 15);
            if (idx == 0)
                return '0;
            if (idx == 1)
                return ALL_ONES;
            return 32'hA5A5_0000 | idx;
        end
        return $urandom();
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        position <= pos;
        item_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(apply_list_op(op, pos, val));
    endtask

    // Drifts the list length between empty and full, lingering a little at each end.
    task automatic send_random_request();
        int len;
        int r;
        logic [OP_W-1:0] op;
        logic [POS_W-1:0] pos;
        len = list_shadow.size();
        if (len == CAPACITY_DEF && $urandom_range(0, 3) == 0)
            growing = 1'b0;
        else if (len == 0 && $urandom_range(0, 3) == 0)
            growing = 1'b1;
        else if ($urandom_range(0, 149) == 0)
            growing = !growing;
        r = $urandom_range(0, 99);
        if (r < (growing ? 35 : 5))
            op = OP_APPEND;
        else if (r < (growing ? 60 : 12))
            op = OP_INSERT;
        else if (r < 70)
            op = OP_REMOVE;
        else if (r < 82)
            op = OP_GET;
        else if (r < 96)
            op = OP_SEARCH;
        else
            op = OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
        if (op == OP_INSERT)
            pos = pick_position(len);
        else if (op == OP_REMOVE || op == OP_GET)
            pos = pick_position(len - 1);
        else
            pos = POS_W'($urandom_range(0, 127));
        send_request(op, pos, pick_handle(op == OP_SEARCH ? 50 : 10));
    endtask

    task automatic test_directed_edges();
        send_request(OP_GET, 7'd0, '0);
        send_request(OP_REMOVE, 7'd0, '0);
        send_request(OP_SEARCH, 7'd0, '0);
        send_request(OP_INSERT, 7'd1, 32'h0000_0011);
        send_request(OP_INSERT, 7'd0, ALL_ONES);
        send_request(OP_APPEND, 7'd0, '0);
        send_request(OP_APPEND, 7'd0, 32'h8000_0001);
        send_request(OP_INSERT, 7'd3, 32'h1234_5678);   // at the end, same as append
        send_request(OP_INSERT, 7'd5, 32'h0000_0022);
        send_request(OP_INSERT, 7'd127, 32'h0000_0033);
        send_request(OP_INSERT, 7'd1, 32'h7FFF_FFFE);
        send_request(OP_GET, 7'd0, '0);
        send_request(OP_GET, 7'd4, '0);
        send_request(OP_GET, 7'd5, '0);
        send_request(OP_GET, 7'd64, '0);
        send_request(OP_SEARCH, 7'd0, 32'h8000_0001);
        send_request(OP_SEARCH, 7'd0, 32'h0000_0002);
        send_request(OP_REMOVE, 7'd2, '0);
        send_request(OP_REMOVE, 7'd3, '0);
        send_request(OP_REMOVE, 7'd3, '0);
        send_request(OP_SPARE_5, 7'd127, ALL_ONES);
        send_request(OP_SPARE_6, 7'd0, ALL_ONES);
        send_request(OP_SPARE_7, 7'd1, '0);
        send_request(OP_SEARCH, 7'd0, '0);
        send_request(OP_REMOVE, 7'd0, '0);
    endtask

    task automatic test_fill_and_drain();
        while (list_shadow.size() < CAPACITY_DEF)
            send_request(OP_APPEND, POS_W'($urandom_range(0, 127)), pick_handle(0));
        send_request(OP_APPEND, 7'd0, 32'hDEAD_0001);
        send_request(OP_INSERT, 7'd0, 32'hDEAD_0002);
        send_request(OP_INSERT, 7'd64, 32'hDEAD_0003);
        send_request(OP_GET, 7'd63, '0);
        send_request(OP_GET, 7'd64, '0);
        send_request(OP_REMOVE, 7'd64, '0);
        send_request(OP_SEARCH, 7'd0, list_shadow[CAPACITY_DEF - 1]);
        while (list_shadow.size() != 0)
            send_request(OP_REMOVE, POS_W'($urandom_range(0, list_shadow.size() - 1)), '0);
    endtask

    // The sink holds off while the source keeps offering, so the result register
    // fills and the input stalls until the hold ends.
    task automatic test_backpressure_fill();
        int k;
        k = 0;
        steady = 1'b1;
        long_hold_cycles = HOLD_CYCLES;
        while (k < 12 || long_hold_cycles != 0)
        begin
            send_random_request();
            k++;
        end
        steady = 1'b0;
    endtask

    task automatic test_steady_stream(input int n_items);
        steady = 1'b1;
        repeat (n_items) send_random_request();
        steady = 1'b0;
    endtask

    task automatic test_random_traffic(input int n_items);
        repeat (n_items) send_random_request();
    endtask

    initial
    begin : result_sink
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_cycles != 0)
            begin
                out_ready <= 1'b0;
                repeat (long_hold_cycles) @(posedge clk);
                long_hold_cycles = 0;
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    task automatic check_result();
        list_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result transfer with no request outstanding");
            return;
        end
        want = expected_results.pop_front();
        if (success !== want.success)
            report_mismatch($sformatf("success %b, expected %b", success, want.success));
        if (read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, expected %h", read_value,
                                      want.read_value));
        if (found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", found, want.found));
        if (length !== want.length)
            report_mismatch($sformatf("length %0d, expected %0d", length, want.length));
        if (is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %b, expected %b", is_empty, want.is_empty));
        result_index++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result();
    end

    initial
    begin : run_regression
        int waited;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_APPEND;
        position = '0;
        item_value = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_fill_and_drain();
        test_backpressure_fill();
        test_steady_stream(200);
        test_random_traffic(1000);
        in_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        // Extra waiting after the drain catches any stray transfer.
        repeat (5) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : watchdog
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bole_pkg.sv
rtl/bole_cell.sv
rtl/bounded_ordered_list_engine.sv
tb/sv/tb_bounded_ordered_list_engine.sv
